@@ rtl/rc4_pkg.sv @@
package rc4_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int BYTE_W      = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t LAST_INDEX = byte_t'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_KEY  = 2'd1,
    OP_SCHEDULE  = 2'd2,
    OP_CRYPT     = 2'd3
  } op_t;

  // one read and one write request to a table in a cycle
  typedef struct packed {
    logic  rd;
    byte_t rd_addr;
    logic  wr;
    byte_t wr_addr;
    byte_t wr_data;
  } mem_req_t;

endpackage

@@ rtl/rc4_ifs.sv @@
interface rc4_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  rc4_pkg::byte_t     index;
  rc4_pkg::byte_t     data_byte;

  modport source (output valid, output operation, output index, output data_byte, input ready);
  modport sink   (input valid, input operation, input index, input data_byte, output ready);
endinterface

interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

@@ rtl/rc4_tables.sv @@
module rc4_tables (
  input  logic              clk,
  input  rc4_pkg::mem_req_t perm_req,
  input  rc4_pkg::mem_req_t key_req,
  output rc4_pkg::byte_t    perm_q,
  output rc4_pkg::byte_t    key_q
);
  import rc4_pkg::*;

  byte_t perm_mem [TABLE_DEPTH];
  byte_t key_mem  [TABLE_DEPTH];

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (perm_req.wr) perm_mem[perm_req.wr_addr] <= perm_req.wr_data;
    if (perm_req.rd) perm_q <= perm_mem[perm_req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_req.wr) key_mem[key_req.wr_addr] <= key_req.wr_data;
    if (key_req.rd) key_q <= key_mem[key_req.rd_addr];
  end

endmodule

@@ rtl/rc4_seq.sv @@
module rc4_seq (
  input  logic              clk,
  input  logic              rst,
  rc4_in_if.sink            din,
  input  logic              res_ready,
  output logic              res_valid,
  output rc4_pkg::byte_t    res_byte,
  output rc4_pkg::mem_req_t perm_req,
  output rc4_pkg::mem_req_t key_req,
  input  rc4_pkg::byte_t    perm_q,
  input  rc4_pkg::byte_t    key_q
);
  import rc4_pkg::*;

  typedef enum logic [1:0] {IDLE, FETCH_J, SWAP_A, SWAP_J} state_t;

  state_t state;
  logic   sched;
  logic   fwd_a;
  logic   ks_fwd;
  byte_t  ptr_i, ptr_j;
  byte_t  a, jj, sa, d, ks_val;

  logic   in_xfer;
  byte_t  sa_cur, j_sum, ks_addr, keystream, a_inc, ptr_i_inc;

  assign din.ready = (state == IDLE);
  assign in_xfer   = din.valid && din.ready;

  assign a_inc     = a + byte_t'(1);
  assign ptr_i_inc = ptr_i + byte_t'(1);
  // S[a] was just rewritten by the previous swap when a hit its j
  assign sa_cur    = fwd_a ? sa : perm_q;
  assign j_sum     = jj + sa_cur + (sched ? key_q : byte_t'(0));
  assign ks_addr   = sa + perm_q;
  assign keystream = ks_fwd ? ks_val : perm_q;
  assign res_byte  = d ^ keystream;
  assign res_valid = (state == SWAP_J) && !sched;

  always_comb begin
    perm_req = '0;
    key_req  = '0;
    unique case (state)
      IDLE: begin
        if (in_xfer) begin
          unique case (din.operation)
            OP_LOAD_PERM: begin
              perm_req.wr      = 1'b1;
              perm_req.wr_addr = din.index;
              perm_req.wr_data = din.data_byte;
            end
            OP_LOAD_KEY: begin
              key_req.wr      = 1'b1;
              key_req.wr_addr = din.index;
              key_req.wr_data = din.data_byte;
            end
            OP_SCHEDULE: begin
              perm_req.rd = 1'b1;
              key_req.rd  = 1'b1;
            end
            OP_CRYPT: begin
              perm_req.rd      = 1'b1;
              perm_req.rd_addr = ptr_i_inc;
            end
          endcase
        end
      end
      FETCH_J: begin
        perm_req.rd      = 1'b1;
        perm_req.rd_addr = j_sum;
      end
      SWAP_A: begin
        perm_req.wr      = 1'b1;
        perm_req.wr_addr = a;
        perm_req.wr_data = perm_q;
        if (!sched) begin
          perm_req.rd      = 1'b1;
          perm_req.rd_addr = ks_addr;
        end
      end
      SWAP_J: begin
        perm_req.wr      = 1'b1;
        perm_req.wr_addr = jj;
        perm_req.wr_data = sa;
        if (sched && (a != LAST_INDEX)) begin
          perm_req.rd      = 1'b1;
          perm_req.rd_addr = a_inc;
          key_req.rd       = 1'b1;
          key_req.rd_addr  = a_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      sched <= 1'b0;
      fwd_a <= 1'b0;
      ptr_i <= '0;
      ptr_j <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            unique case (din.operation)
              OP_LOAD_PERM, OP_LOAD_KEY: ;
              OP_SCHEDULE: begin
                sched <= 1'b1;
                a     <= '0;
                jj    <= '0;
                fwd_a <= 1'b0;
                state <= FETCH_J;
              end
              OP_CRYPT: begin
                sched <= 1'b0;
                a     <= ptr_i_inc;
                jj    <= ptr_j;
                d     <= din.data_byte;
                fwd_a <= 1'b0;
                state <= FETCH_J;
              end
            endcase
          end
        end
        FETCH_J: begin
          sa    <= sa_cur;
          jj    <= j_sum;
          state <= SWAP_A;
        end
        SWAP_A: begin
          // keystream entry may be one of the two being swapped
          ks_fwd <= (ks_addr == a) || (ks_addr == jj);
          ks_val <= (ks_addr == a) ? perm_q : sa;
          state  <= SWAP_J;
        end
        SWAP_J: begin
          if (sched) begin
            if (a == LAST_INDEX) begin
              ptr_i <= '0;
              ptr_j <= '0;
              state <= IDLE;
            end else begin
              a     <= a_inc;
              fwd_a <= (a_inc == jj);
              state <= FETCH_J;
            end
          end else if (res_ready) begin
            ptr_i <= a;
            ptr_j <= jj;
            state <= IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/rc4_stream_cipher_unit.sv @@
// channel | modport | payload                        | moves
// din     | sink    | operation, index, data_byte    | one command per transfer
// dout    | source  | out_byte                       | one byte per crypt command
//
// A crypt byte issues three dependent reads of the permutation store, which has
// one read and one write port, then the second swap write.
// Key schedule: 256 swap steps, each through FETCH_J, SWAP_A and SWAP_J.
// Reset clears i, j and the sequencer; table contents stay undefined until loaded.
// A crypt waits in its last step while the output register holds an untaken byte.
module rc4_stream_cipher_unit (
  input logic        clk,
  input logic        rst,
  rc4_in_if.sink     din,
  rc4_out_if.source  dout
);
  import rc4_pkg::*;

  mem_req_t perm_req, key_req;
  byte_t    perm_q, key_q;
  logic     res_valid, res_ready;
  byte_t    res_byte;
  logic     out_valid;
  byte_t    out_byte;

  rc4_tables u_tables (
    .clk      (clk),
    .perm_req (perm_req),
    .key_req  (key_req),
    .perm_q   (perm_q),
    .key_q    (key_q)
  );

  rc4_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_byte  (res_byte),
    .perm_req  (perm_req),
    .key_req   (key_req),
    .perm_q    (perm_q),
    .key_q     (key_q)
  );

  assign res_ready     = !out_valid || dout.ready;
  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_byte <= res_byte;
  end

  logic run_xfer, crypt_xfer;
  assign run_xfer   = din.valid && din.ready &&
                      (din.operation == OP_SCHEDULE || din.operation == OP_CRYPT);
  assign crypt_xfer = din.valid && din.ready && (din.operation == OP_CRYPT);

  a_busy_after_run: assert property (@(posedge clk) disable iff (rst)
    run_xfer |=> !din.ready)
    else $error("sequencer took a new command while running");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    crypt_xfer |=> !res_valid ##1 !res_valid)
    else $error("crypt result before the swap completed");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte))
    else $error("stalled crypt result changed");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rc4_pkg::*;

  localparam int IDLE_LIMIT  = 4000;  // a key schedule accepts no commands while it runs
  localparam int TAIL_CYCLES = 20;

  class cipher_scoreboard;
    byte_t perm[TABLE_DEPTH];
    byte_t key_bytes[TABLE_DEPTH];
    byte_t ptr_i;
    byte_t ptr_j;
    byte_t out_q[$];
    int    errors;

    function new();
      ptr_i  = '0;
      ptr_j  = '0;
      errors = 0;
    endfunction

    function void swap(byte_t a, byte_t b);
      byte_t t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    endfunction

    // schedule keeps its own j, starting at zero every run
    function void run_schedule();
      byte_t j;
      j = '0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        j = j + perm[n] + key_bytes[n];
        swap(byte_t'(n), j);
      end
      ptr_i = '0;
      ptr_j = '0;
    endfunction

    function byte_t keystream_byte();
      byte_t sum;
      ptr_i = ptr_i + 8'd1;
      ptr_j = ptr_j + perm[ptr_i];
      swap(ptr_i, ptr_j);
      sum = perm[ptr_i] + perm[ptr_j];
      return perm[sum];
    endfunction

    function void note_command(op_t op, byte_t idx, byte_t data);
      case (op)
        OP_LOAD_PERM: perm[idx] = data;
        OP_LOAD_KEY:  key_bytes[idx] = data;
        OP_SCHEDULE:  run_schedule();
        OP_CRYPT:     out_q.push_back(data ^ keystream_byte());
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_out_byte(byte_t got);
      byte_t want;
      if (out_q.size() == 0) begin
        report($sformatf("unexpected out_byte %h", got));
      end else begin
        want = out_q.pop_front();
        if (got !== want)
          report($sformatf("out_byte got %h, want %h", got, want));
      end
    endtask

    function int pending();
      return out_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rc4_in_if  din_bus ();
  rc4_out_if dout_bus ();

  rc4_stream_cipher_unit uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus)
  );

  cipher_scoreboard sb = new();

  int idle_cycles = 0;
  int src_left = 0;
  bit src_calm = 1'b0;
  int snk_left = 0;
  bit snk_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap per transfer, with runs of back-to-back transfers mixed in
  function automatic int draw_gap(ref int left, ref bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_command(op_t op, byte_t idx, byte_t data);
    int gap;
    gap = draw_gap(src_left, src_calm);
    if (gap > 0) begin
      din_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_bus.valid     <= 1'b1;
    din_bus.operation <= op;
    din_bus.index     <= idx;
    din_bus.data_byte <= data;
    do @(posedge clk); while (din_bus.ready !== 1'b1);
    sb.note_command(op, idx, data);
  endtask

  task automatic hold_until_drained();
    din_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic load_identity();
    for (int n = 0; n < TABLE_DEPTH; n++)
      send_command(OP_LOAD_PERM, byte_t'(n), byte_t'(n));
  endtask

  task automatic load_key(int len);
    byte_t kb[TABLE_DEPTH];
    for (int n = 0; n < len; n++)
      kb[n] = rand_byte();
    for (int n = 0; n < TABLE_DEPTH; n++)
      send_command(OP_LOAD_KEY, byte_t'(n), kb[n % len]);
  endtask

  // both tables are fully written before this runs, so any index is safe
  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_command(OP_CRYPT, rand_byte(), rand_byte());
      end else if (r < 82) begin
        send_command(OP_LOAD_PERM, rand_byte(), rand_byte());
      end else if (r < 92) begin
        send_command(OP_LOAD_KEY, rand_byte(), rand_byte());
      end else if (r < 96) begin
        send_command(OP_SCHEDULE, rand_byte(), rand_byte());
      end else begin
        hold_until_drained();
        send_command(OP_CRYPT, rand_byte(), rand_byte());
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    dout_bus.ready <= 1'b0;
    do @(posedge clk); while (rst === 1'b1);
    forever begin
      gap = draw_gap(snk_left, snk_calm);
      if (gap > 0) begin
        dout_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dout_bus.ready <= 1'b1;
      do @(posedge clk); while (dout_bus.valid !== 1'b1);
      sb.check_out_byte(dout_bus.out_byte);
    end
  end

  always @(posedge clk) begin
    if ((din_bus.valid && din_bus.ready) === 1'b1 ||
        (dout_bus.valid && dout_bus.ready) === 1'b1)
      idle_cycles <= 0;
    else if (rst !== 1'b1)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rc4_stream_cipher_unit test failed");
      $finish;
    end
  end

  initial begin
    int key_len;
    rst               <= 1'b1;
    din_bus.valid     <= 1'b0;
    din_bus.operation <= OP_CRYPT;
    din_bus.index     <= '0;
    din_bus.data_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    load_identity();
    load_key($urandom_range(1, 16));

    // crypt straight off the loaded tables, no schedule yet
    send_command(OP_CRYPT, 8'h00, 8'h00);
    send_command(OP_CRYPT, 8'hFF, 8'hFF);

    send_command(OP_SCHEDULE, 8'hA5, 8'h5A);
    send_command(OP_CRYPT, 8'h00, 8'h00);
    send_command(OP_CRYPT, 8'hFF, 8'hFF);
    send_command(OP_CRYPT, 8'h5A, 8'h55);
    send_command(OP_CRYPT, 8'hA5, 8'hAA);
    send_command(OP_CRYPT, 8'h01, 8'h80);
    send_command(OP_CRYPT, 8'h80, 8'h01);

    // table edges, then two schedules back to back
    send_command(OP_LOAD_PERM, 8'h00, 8'hFF);
    send_command(OP_LOAD_PERM, LAST_INDEX, 8'h00);
    send_command(OP_LOAD_KEY, 8'h00, 8'h00);
    send_command(OP_LOAD_KEY, LAST_INDEX, 8'hFF);
    send_command(OP_SCHEDULE, 8'h00, 8'hFF);
    send_command(OP_SCHEDULE, 8'hFF, 8'h00);
    send_command(OP_CRYPT, 8'h3C, 8'hC3);
    send_command(OP_CRYPT, 8'hC3, 8'h3C);

    hold_until_drained();
    send_command(OP_CRYPT, 8'h12, 8'h34);

    random_phase(220);

    // fresh message: identity permutation, new key, schedule, then traffic
    hold_until_drained();
    load_identity();
    case ($urandom_range(0, 2))
      0:       key_len = 1;
      1:       key_len = TABLE_DEPTH;
      default: key_len = $urandom_range(2, 32);
    endcase
    load_key(key_len);
    send_command(OP_SCHEDULE, rand_byte(), rand_byte());
    random_phase(200);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("rc4_stream_cipher_unit test passed");
    else
      $display("rc4_stream_cipher_unit test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rc4_pkg.sv
rtl/rc4_ifs.sv
rtl/rc4_tables.sv
rtl/rc4_seq.sv
rtl/rc4_stream_cipher_unit.sv
tb/tb_top.sv
